@@ src/strain_rate_tensor_magnitude_macros.svh @@
// Assertion macros shared by the strain-rate tensor RTL.
`ifndef STRAIN_RATE_TENSOR_MAGNITUDE_MACROS_SVH
`define STRAIN_RATE_TENSOR_MAGNITUDE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define SRTM_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srtm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SRTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srtm: next-cycle check failed");

`else

`define SRTM_ASSERT_IMPLIES(lbl, ante, cons)
`define SRTM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/srtm_pkg.sv @@
// Package with widths, word types and pipeline control type of the strain-rate block.
`default_nettype none

package srtm_pkg;

  // Gradient and strain width; values are signed Q16.16.
  localparam int DATA_WIDTH = 32;
  // Magnitude width: the root of the largest sum of squares fits in three extra bits.
  localparam int MAG_WIDTH  = DATA_WIDTH + 3;
  // Sum of two gradients before halving.
  localparam int SUM_WIDTH  = DATA_WIDTH + 1;
  // Square of a magnitude of at most 2^(DATA_WIDTH-1).
  localparam int SQ_WIDTH   = 2 * DATA_WIDTH;
  // Sum of three squares.
  localparam int ACC_WIDTH  = SQ_WIDTH + 2;
  // Radicand fed to the square root, two bits per result bit.
  localparam int RAD_WIDTH  = 2 * MAG_WIDTH;
  // Partial remainder of the square root.
  localparam int REM_WIDTH  = MAG_WIDTH + 1;
  // Number of independent strain components.
  localparam int NUM_STRAIN = 6;

  // Positions of the strain components in the squaring lanes.
  localparam int LANE_S11 = 0;
  localparam int LANE_S12 = 1;
  localparam int LANE_S13 = 2;
  localparam int LANE_S22 = 3;
  localparam int LANE_S23 = 4;
  localparam int LANE_S33 = 5;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    data_t grad_u1_x1;
    data_t grad_u1_x2;
    data_t grad_u1_x3;
    data_t grad_u2_x1;
    data_t grad_u2_x2;
    data_t grad_u2_x3;
    data_t grad_u3_x1;
    data_t grad_u3_x2;
    data_t grad_u3_x3;
  } in_word_t;

  typedef struct packed {
    data_t strain_11;
    data_t strain_12;
    data_t strain_13;
    data_t strain_22;
    data_t strain_23;
    data_t strain_33;
  } strain_t;

  typedef struct packed {
    data_t                  strain_11;
    data_t                  strain_12;
    data_t                  strain_13;
    data_t                  strain_22;
    data_t                  strain_23;
    data_t                  strain_33;
    logic [MAG_WIDTH-1:0]   strain_magnitude;
  } out_word_t;

  // Pipeline advance and the valid bit entering a pipeline section.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

`default_nettype wire

@@ src/srtm_front.sv @@
// Front pipeline: strain components, magnitudes, squares and the exact radicand.
`default_nettype none

module srtm_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  srtm_pkg::pipe_ctl_t           ctl,
  input  srtm_pkg::in_word_t            in_word,
  output logic                          out_valid,
  output logic [srtm_pkg::RAD_WIDTH-1:0] rad_out,
  output srtm_pkg::strain_t             strain_out
);

  localparam int DW  = srtm_pkg::DATA_WIDTH;
  localparam int NS  = srtm_pkg::NUM_STRAIN;
  localparam int SQW = srtm_pkg::SQ_WIDTH;
  localparam int ACW = srtm_pkg::ACC_WIDTH;
  localparam int RW  = srtm_pkg::RAD_WIDTH;

  // Valid bits of the five stages.
  logic [4:0] v_r;

  // Stage 1: strain components.
  srtm_pkg::strain_t st1_r, st1_nxt;
  // Stage 2: absolute values.
  srtm_pkg::strain_t st2_r;
  logic [DW-1:0]     mag2_r [NS];
  logic [DW-1:0]     mag2_nxt [NS];
  // Stage 3: squares.
  srtm_pkg::strain_t st3_r;
  logic [SQW-1:0]    sq3_r [NS];
  logic [SQW-1:0]    sq3_nxt [NS];
  // Stage 4: diagonal and off-diagonal sums.
  srtm_pkg::strain_t st4_r;
  logic [ACW-1:0]    diag4_r, diag4_nxt;
  logic [ACW-1:0]    offd4_r, offd4_nxt;
  // Stage 5: radicand 2*diag + 4*offd.
  srtm_pkg::strain_t st5_r;
  logic [RW-1:0]     rad5_r, rad5_nxt;

  logic [srtm_pkg::SUM_WIDTH-1:0] sum12, sum13, sum23;
  srtm_pkg::data_t                lane_val [NS];

  // Off-diagonal terms are the floor half of a one-bit-wider sum.
  always_comb begin
    sum12 = {in_word.grad_u1_x2[DW-1], in_word.grad_u1_x2}
          + {in_word.grad_u2_x1[DW-1], in_word.grad_u2_x1};
    sum13 = {in_word.grad_u1_x3[DW-1], in_word.grad_u1_x3}
          + {in_word.grad_u3_x1[DW-1], in_word.grad_u3_x1};
    sum23 = {in_word.grad_u2_x3[DW-1], in_word.grad_u2_x3}
          + {in_word.grad_u3_x2[DW-1], in_word.grad_u3_x2};
    st1_nxt.strain_11 = in_word.grad_u1_x1;
    st1_nxt.strain_12 = sum12[DW:1];
    st1_nxt.strain_13 = sum13[DW:1];
    st1_nxt.strain_22 = in_word.grad_u2_x2;
    st1_nxt.strain_23 = sum23[DW:1];
    st1_nxt.strain_33 = in_word.grad_u3_x3;
  end

  // Magnitudes; the most negative value maps to 2^(DW-1) as an unsigned word.
  always_comb begin
    lane_val[srtm_pkg::LANE_S11] = st1_r.strain_11;
    lane_val[srtm_pkg::LANE_S12] = st1_r.strain_12;
    lane_val[srtm_pkg::LANE_S13] = st1_r.strain_13;
    lane_val[srtm_pkg::LANE_S22] = st1_r.strain_22;
    lane_val[srtm_pkg::LANE_S23] = st1_r.strain_23;
    lane_val[srtm_pkg::LANE_S33] = st1_r.strain_33;
    for (int k = 0; k < NS; k++) begin
      mag2_nxt[k] = lane_val[k][DW-1] ? (~lane_val[k] + 1'b1) : lane_val[k];
    end
  end

  // One DW x DW multiplier per lane.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      sq3_nxt[k] = mag2_r[k] * mag2_r[k];
    end
  end

  // Three-input sums of the diagonal and off-diagonal squares, and the radicand 2*diag + 4*offd.
  always_comb begin
    diag4_nxt = {2'b00, sq3_r[srtm_pkg::LANE_S11]}
              + {2'b00, sq3_r[srtm_pkg::LANE_S22]}
              + {2'b00, sq3_r[srtm_pkg::LANE_S33]};
    offd4_nxt = {2'b00, sq3_r[srtm_pkg::LANE_S12]}
              + {2'b00, sq3_r[srtm_pkg::LANE_S13]}
              + {2'b00, sq3_r[srtm_pkg::LANE_S23]};
    rad5_nxt  = {{(RW-ACW-1){1'b0}}, diag4_r, 1'b0}
              + {{(RW-ACW-2){1'b0}}, offd4_r, 2'b00};
  end

  // Valid bits follow the data and hold on a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl.en) begin
      v_r <= {v_r[3:0], ctl.valid};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      st1_r   <= st1_nxt;
      st2_r   <= st1_r;
      mag2_r  <= mag2_nxt;
      st3_r   <= st2_r;
      sq3_r   <= sq3_nxt;
      st4_r   <= st3_r;
      diag4_r <= diag4_nxt;
      offd4_r <= offd4_nxt;
      st5_r   <= st4_r;
      rad5_r  <= rad5_nxt;
    end
  end

  assign out_valid  = v_r[4];
  assign rad_out    = rad5_r;
  assign strain_out = st5_r;

endmodule

`default_nettype wire

@@ src/srtm_sqrt.sv @@
// Pipelined restoring square root, one result bit per stage, strain words carried alongside.
`default_nettype none

`include "strain_rate_tensor_magnitude_macros.svh"

module srtm_sqrt (
  input  wire                            clk,
  input  wire                            rst_n,
  input  srtm_pkg::pipe_ctl_t            ctl,
  input  wire [srtm_pkg::RAD_WIDTH-1:0]  rad_in,
  input  srtm_pkg::strain_t              side_in,
  output logic                           out_valid,
  output logic [srtm_pkg::MAG_WIDTH-1:0] root_out,
  output srtm_pkg::strain_t              side_out
);

  localparam int M  = srtm_pkg::MAG_WIDTH;
  localparam int RW = srtm_pkg::RAD_WIDTH;
  localparam int EW = srtm_pkg::REM_WIDTH;

  // Per-stage registers.
  logic [M-1:0]      v_r;
  logic [EW-1:0]     rem_r  [M];
  logic [M-1:0]      root_r [M];
  logic [RW-1:0]     rad_r  [M];
  srtm_pkg::strain_t side_r [M];

  // Per-stage combinational values.
  logic [EW-1:0]     src_rem  [M];
  logic [M-1:0]      src_root [M];
  logic [RW-1:0]     src_rad  [M];
  logic [EW+1:0]     rem2     [M];
  logic [EW+2:0]     diff     [M];
  logic [M-1:0]      take;
  logic [EW-1:0]     rem_nxt  [M];
  logic [M-1:0]      root_nxt [M];
  logic [RW-1:0]     rad_nxt  [M];

  // Each stage brings down two radicand bits and tries the next root bit.
  always_comb begin
    for (int k = 0; k < M; k++) begin
      if (k == 0) begin
        src_rem[k]  = '0;
        src_root[k] = '0;
        src_rad[k]  = rad_in;
      end else begin
        src_rem[k]  = rem_r[k-1];
        src_root[k] = root_r[k-1];
        src_rad[k]  = rad_r[k-1];
      end
      rem2[k]     = {src_rem[k], src_rad[k][RW-1 -: 2]};
      diff[k]     = {1'b0, rem2[k]} - {2'b00, src_root[k], 2'b01};
      take[k]     = ~diff[k][EW+2];
      rem_nxt[k]  = take[k] ? diff[k][EW-1:0] : rem2[k][EW-1:0];
      root_nxt[k] = {src_root[k][M-2:0], take[k]};
      rad_nxt[k]  = {src_rad[k][RW-3:0], 2'b00};
    end
  end

  // Valid bits shift with the data and hold on a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl.en) begin
      v_r <= {v_r[M-2:0], ctl.valid};
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < M; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        side_r[k] <= (k == 0) ? side_in : side_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_valid = v_r[M-1];
  assign root_out  = root_r[M-1];
  assign side_out  = side_r[M-1];

  // A finished root leaves a remainder no larger than twice the root.
  `SRTM_ASSERT_IMPLIES(a_rem_bound, v_r[M-1], rem_r[M-1] <= {root_r[M-1], 1'b0})
  // A stall freezes the valid pattern.
  `SRTM_ASSERT_NEXT(a_stall_holds, !ctl.en, $stable(v_r))

endmodule

`default_nettype wire

@@ src/strain_rate_tensor_magnitude.sv @@
// Top level: strain-rate tensor and magnitude pipeline with output skid stage.
//
// Takes one word of nine velocity gradients (signed Q16.16) per cycle and returns
// the six strain-rate components and the floor square root of 2*Sij*Sij as an
// unsigned Q19.16 magnitude. A word is accepted in every cycle while the output
// side keeps taking results. On its way to out_valid a word passes the five front
// stages (halving, absolute value, squaring, sums, radicand), then one stage per
// magnitude bit of the square root (35) and the output register, 41 registers
// in all. A two-entry output stage (register plus skid) lets the pipeline take
// a word while a finished result waits; the pipeline stalls as a whole only once
// the skid entry is occupied.
`default_nettype none

`include "strain_rate_tensor_magnitude_macros.svh"

module strain_rate_tensor_magnitude (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  srtm_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output srtm_pkg::out_word_t  out_data
);

  srtm_pkg::pipe_ctl_t front_ctl, sqrt_ctl;

  logic                            front_valid;
  logic [srtm_pkg::RAD_WIDTH-1:0]  front_rad;
  srtm_pkg::strain_t               front_strain;

  logic                            pipe_valid;
  logic [srtm_pkg::MAG_WIDTH-1:0]  pipe_root;
  srtm_pkg::strain_t               pipe_strain;

  logic                 pipe_en;
  logic                 push;
  srtm_pkg::out_word_t  push_word;

  logic                 out_valid_r;
  srtm_pkg::out_word_t  out_data_r;
  logic                 skid_valid_r;
  srtm_pkg::out_word_t  skid_data_r;

  // The whole pipeline advances while the skid entry is free.
  assign pipe_en   = ~skid_valid_r;
  assign in_ready  = pipe_en;
  assign front_ctl = '{en: pipe_en, valid: in_valid};
  assign sqrt_ctl  = '{en: pipe_en, valid: front_valid};

  srtm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (front_ctl),
    .in_word    (in_data),
    .out_valid  (front_valid),
    .rad_out    (front_rad),
    .strain_out (front_strain)
  );

  srtm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sqrt_ctl),
    .rad_in    (front_rad),
    .side_in   (front_strain),
    .out_valid (pipe_valid),
    .root_out  (pipe_root),
    .side_out  (pipe_strain)
  );

  // Result word leaving the last pipeline stage.
  always_comb begin
    push                       = pipe_en & pipe_valid;
    push_word.strain_11        = pipe_strain.strain_11;
    push_word.strain_12        = pipe_strain.strain_12;
    push_word.strain_13        = pipe_strain.strain_13;
    push_word.strain_22        = pipe_strain.strain_22;
    push_word.strain_23        = pipe_strain.strain_23;
    push_word.strain_33        = pipe_strain.strain_33;
    push_word.strain_magnitude = pipe_root;
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_word;
    end else if (push) begin
      skid_data_r <= push_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The skid entry is only ever filled behind a waiting output word.
  `SRTM_ASSERT_IMPLIES(a_skid_behind_head, skid_valid_r, out_valid_r)
  // A result that arrives while the output is blocked lands in the skid entry.
  `SRTM_ASSERT_NEXT(a_push_parks, push && out_valid_r && !out_ready, skid_valid_r)
  // While the skid entry is full the input side is closed.
  `SRTM_ASSERT_IMPLIES(a_full_blocks, skid_valid_r, !push)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the strain-rate tensor and magnitude pipeline.
`default_nettype none

module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_WORDS = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  srtm_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srtm_pkg::out_word_t out_data;

  // Gradient words waiting to be sent and strain results waiting to arrive.
  srtm_pkg::in_word_t pending_points[$];
  srtm_pkg::out_word_t expected_strain[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  strain_rate_tensor_magnitude u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Exact square of a signed gradient, held in 128 bits.
  function automatic logic [127:0] square_wide(srtm_pkg::data_t v);
    logic [127:0] m;
    m = {{96{v[srtm_pkg::DATA_WIDTH-1]}}, v};
    if (v[srtm_pkg::DATA_WIDTH-1]) begin
      m = -m;
    end
    return m * m;
  endfunction

  // Floor of (a + b) / 2, formed on one extra bit so the sum never wraps.
  function automatic srtm_pkg::data_t floor_half_sum(srtm_pkg::data_t a, srtm_pkg::data_t b);
    logic signed [srtm_pkg::DATA_WIDTH:0] s;
    s = $signed({a[srtm_pkg::DATA_WIDTH-1], a}) + $signed({b[srtm_pkg::DATA_WIDTH-1], b});
    return s[srtm_pkg::DATA_WIDTH:1];
  endfunction

  // Strain components and the floor root of 2*Sij*Sij for one grid point.
  function automatic srtm_pkg::out_word_t predict_strain(srtm_pkg::in_word_t g);
    srtm_pkg::out_word_t r;
    logic [127:0] diag_sum;
    logic [127:0] cross_sum;
    logic [127:0] radicand;
    logic [127:0] root;
    logic [127:0] trial;
    r.strain_11 = g.grad_u1_x1;
    r.strain_22 = g.grad_u2_x2;
    r.strain_33 = g.grad_u3_x3;
    r.strain_12 = floor_half_sum(g.grad_u1_x2, g.grad_u2_x1);
    r.strain_13 = floor_half_sum(g.grad_u1_x3, g.grad_u3_x1);
    r.strain_23 = floor_half_sum(g.grad_u2_x3, g.grad_u3_x2);
    diag_sum = square_wide(r.strain_11) + square_wide(r.strain_22) + square_wide(r.strain_33);
    cross_sum = square_wide(r.strain_12) + square_wide(r.strain_13)
              + square_wide(r.strain_23);
    radicand = (diag_sum << 1) + (cross_sum << 2);
    // Decide the root one bit at a time from the top.
    root = '0;
    for (int i = srtm_pkg::MAG_WIDTH + 1; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= radicand) begin
        root = trial;
      end
    end
    r.strain_magnitude = root[srtm_pkg::MAG_WIDTH-1:0];
    return r;
  endfunction

  // Gradient values by mode: full-range random, small values around zero, or the edges of the signed range.
  function automatic srtm_pkg::data_t pick_gradient(int mode);
    int unsigned roll;
    roll = $urandom_range(4);
    case (mode)
      0: return srtm_pkg::data_t'($urandom);
      1: return srtm_pkg::data_t'($signed($urandom_range(2048)) - 1024);
      2: begin
        case (roll)
          0: return {1'b1, {(srtm_pkg::DATA_WIDTH-1){1'b0}}};
          1: return {1'b0, {(srtm_pkg::DATA_WIDTH-1){1'b1}}};
          2: return '1;
          3: return srtm_pkg::data_t'(1);
          default: return '0;
        endcase
      end
      default: return pick_gradient($urandom_range(2));
    endcase
  endfunction

  function automatic srtm_pkg::in_word_t random_point();
    srtm_pkg::in_word_t w;
    int mode;
    mode = $urandom_range(3);
    w = {pick_gradient(mode), pick_gradient(mode), pick_gradient(mode),
         pick_gradient(mode), pick_gradient(mode), pick_gradient(mode),
         pick_gradient(mode), pick_gradient(mode), pick_gradient(mode)};
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Driver: presents the next word once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_strain.push_back(predict_strain(in_data));
      end
      if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_points.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    srtm_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_strain.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data.strain_magnitude), 64'd0);
      end else begin
        want = expected_strain.pop_front();
        if (out_data.strain_11 !== want.strain_11)
          report_mismatch("strain_11", 64'(out_data.strain_11), 64'(want.strain_11));
        if (out_data.strain_12 !== want.strain_12)
          report_mismatch("strain_12", 64'(out_data.strain_12), 64'(want.strain_12));
        if (out_data.strain_13 !== want.strain_13)
          report_mismatch("strain_13", 64'(out_data.strain_13), 64'(want.strain_13));
        if (out_data.strain_22 !== want.strain_22)
          report_mismatch("strain_22", 64'(out_data.strain_22), 64'(want.strain_22));
        if (out_data.strain_23 !== want.strain_23)
          report_mismatch("strain_23", 64'(out_data.strain_23), 64'(want.strain_23));
        if (out_data.strain_33 !== want.strain_33)
          report_mismatch("strain_33", 64'(out_data.strain_33), 64'(want.strain_33));
        if (out_data.strain_magnitude !== want.strain_magnitude)
          report_mismatch("strain_magnitude", 64'(out_data.strain_magnitude),
                          64'(want.strain_magnitude));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Stimulus phases; between phases the sender waits for every result.
  initial begin
    srtm_pkg::data_t dmax;
    srtm_pkg::data_t dmin;
    srtm_pkg::data_t unit;
    logic [9*srtm_pkg::DATA_WIDTH-1:0] one_hot;
    dmax = {1'b0, {(srtm_pkg::DATA_WIDTH-1){1'b1}}};
    dmin = {1'b1, {(srtm_pkg::DATA_WIDTH-1){1'b0}}};
    unit = srtm_pkg::data_t'(1 << 16);

    // Directed points: range edges, odd cross sums of either sign, and one-hot gradients.
    pending_points.push_back('0);
    pending_points.push_back({9{dmax}});
    pending_points.push_back({9{dmin}});
    pending_points.push_back({9{srtm_pkg::data_t'(-1)}});
    pending_points.push_back({9{srtm_pkg::data_t'(1)}});
    pending_points.push_back({dmax, dmax, dmin, dmin, dmax, dmin, dmax, dmin, dmin});
    pending_points.push_back({dmin, srtm_pkg::data_t'(-1), srtm_pkg::data_t'(1),
                              srtm_pkg::data_t'(0), dmax, srtm_pkg::data_t'(3),
                              srtm_pkg::data_t'(0), srtm_pkg::data_t'(-3), dmin});
    pending_points.push_back({srtm_pkg::data_t'(32'hAAAAAAAA), srtm_pkg::data_t'(32'h55555555),
                              srtm_pkg::data_t'(32'hAAAAAAAA), srtm_pkg::data_t'(32'h55555555),
                              srtm_pkg::data_t'(32'hAAAAAAAA), srtm_pkg::data_t'(32'h55555555),
                              srtm_pkg::data_t'(32'hAAAAAAAA), srtm_pkg::data_t'(32'h55555555),
                              srtm_pkg::data_t'(32'hAAAAAAAA)});
    pending_points.push_back({srtm_pkg::data_t'(32'h55555555), srtm_pkg::data_t'(32'hAAAAAAAA),
                              srtm_pkg::data_t'(32'h55555555), srtm_pkg::data_t'(32'hAAAAAAAA),
                              srtm_pkg::data_t'(32'h55555555), srtm_pkg::data_t'(32'hAAAAAAAA),
                              srtm_pkg::data_t'(32'h55555555), srtm_pkg::data_t'(32'hAAAAAAAA),
                              srtm_pkg::data_t'(32'h55555555)});
    for (int k = 0; k < 9; k++) begin
      one_hot = {{(8*srtm_pkg::DATA_WIDTH){1'b0}}, unit} << ((8-k)*srtm_pkg::DATA_WIDTH);
      pending_points.push_back(srtm_pkg::in_word_t'(one_hot));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 54; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 54; end
        default: begin send_idle_pct <= 31; recv_stall_pct <= 31; end
      endcase
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        pending_points.push_back(random_point());
      end
      // Checked between edges so the driver and monitor have settled.
      while (pending_points.size() != 0 || in_valid || expected_strain.size() != 0) begin
        @(negedge clk);
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
